FILE: hdl/vtgd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vtgd_pkg
// Shared types and codes for the vector tile geometry decoder.
// ----------------------------------------------------------------------------
package vtgd_pkg;

  // Command ids carried in bits 2..0 of a command word
  localparam logic [2:0] CMD_MOVE_TO    = 3'd1;
  localparam logic [2:0] CMD_LINE_TO    = 3'd2;
  localparam logic [2:0] CMD_CLOSE_PATH = 3'd7;

  localparam int WORD_W  = 32;
  localparam int COUNT_W = WORD_W - 3;
  localparam int ACC_W   = WORD_W + 2;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_UNKNOWN_CMD = 2'd1,
    STATUS_OUT_OF_RANGE = 2'd2,
    STATUS_TRUNCATED   = 2'd3
  } status_t;

  // One result beat
  typedef struct packed {
    logic signed [WORD_W-1:0] point_x;
    logic signed [WORD_W-1:0] point_y;
    logic                     starts_path;
    logic                     closes_path;
    status_t                  status;
    logic                     last;
  } result_t;

endpackage
`default_nettype wire

FILE: hdl/vtgd_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vtgd_step
// Decoder state and the per-word update for one geometry word.
// ----------------------------------------------------------------------------
module vtgd_step (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             accept,
  input  wire logic [vtgd_pkg::WORD_W-1:0]      word,
  input  wire logic                             end_of_stream,
  output logic                                  res_valid,
  output vtgd_pkg::result_t                     res
);

  logic [2:0]                          command_id;
  logic [2:0]                          command_id_next;
  logic [vtgd_pkg::COUNT_W-1:0]        remaining_count;
  logic [vtgd_pkg::COUNT_W-1:0]        remaining_count_next;
  logic                                awaiting_y;
  logic                                awaiting_y_next;
  logic signed [vtgd_pkg::ACC_W-1:0]   acc_x;
  logic signed [vtgd_pkg::ACC_W-1:0]   acc_x_next;
  logic signed [vtgd_pkg::ACC_W-1:0]   acc_y;
  logic signed [vtgd_pkg::ACC_W-1:0]   acc_y_next;
  logic [vtgd_pkg::WORD_W-1:0]         path_first_x;
  logic [vtgd_pkg::WORD_W-1:0]         path_first_y;
  logic                                first_load;
  logic                                path_nonempty;
  logic                                path_nonempty_next;
  logic                                failed;
  logic                                failed_next;

  logic [2:0]                          cmd_id;
  logic [vtgd_pkg::COUNT_W-1:0]        cmd_count;
  logic [vtgd_pkg::WORD_W-1:0]         zz_word;
  logic signed [vtgd_pkg::ACC_W-1:0]   delta;
  logic signed [vtgd_pkg::ACC_W-1:0]   sum_x;
  logic signed [vtgd_pkg::ACC_W-1:0]   sum_y;
  logic                                x_fits;
  logic                                y_fits;
  logic                                starts;

  // Split the command word and zigzag-decode the parameter word
  assign cmd_id    = word[2:0];
  assign cmd_count = word[vtgd_pkg::WORD_W-1:3];
  assign zz_word   = {1'b0, word[vtgd_pkg::WORD_W-1:1]} ^ {vtgd_pkg::WORD_W{word[0]}};
  assign delta     = {{(vtgd_pkg::ACC_W - vtgd_pkg::WORD_W){zz_word[vtgd_pkg::WORD_W-1]}},
                      zz_word};
  assign sum_x     = acc_x + delta;
  assign sum_y     = acc_y + delta;

  // A coordinate fits in 32 signed bits when its top three bits agree
  assign x_fits = (acc_x[vtgd_pkg::ACC_W-1:vtgd_pkg::WORD_W-1] == 3'b000) ||
                  (acc_x[vtgd_pkg::ACC_W-1:vtgd_pkg::WORD_W-1] == 3'b111);
  assign y_fits = (sum_y[vtgd_pkg::ACC_W-1:vtgd_pkg::WORD_W-1] == 3'b000) ||
                  (sum_y[vtgd_pkg::ACC_W-1:vtgd_pkg::WORD_W-1] == 3'b111);
  assign starts = (command_id == vtgd_pkg::CMD_MOVE_TO) && path_nonempty;

  // Next state and result for the word on the input
  always_comb begin
    command_id_next      = command_id;
    remaining_count_next = remaining_count;
    awaiting_y_next      = awaiting_y;
    acc_x_next           = acc_x;
    acc_y_next           = acc_y;
    path_nonempty_next   = path_nonempty;
    failed_next          = failed;
    first_load           = 1'b0;
    res_valid            = 1'b0;
    res                  = '0;
    res.last             = end_of_stream;

    if (failed) begin
      // drop the word
    end else if (remaining_count == '0) begin
      command_id_next = cmd_id;
      unique case (cmd_id) inside
        vtgd_pkg::CMD_MOVE_TO, vtgd_pkg::CMD_LINE_TO: begin
          remaining_count_next = cmd_count;
          awaiting_y_next      = 1'b0;
          if (end_of_stream && (cmd_count != '0)) begin
            res_valid  = 1'b1;
            res.status = vtgd_pkg::STATUS_TRUNCATED;
          end
        end
        vtgd_pkg::CMD_CLOSE_PATH: begin
          remaining_count_next = '0;
          if (path_nonempty) begin
            res_valid       = 1'b1;
            res.point_x     = path_first_x;
            res.point_y     = path_first_y;
            res.closes_path = 1'b1;
          end
        end
        default: begin
          failed_next = 1'b1;
          res_valid   = 1'b1;
          res.status  = vtgd_pkg::STATUS_UNKNOWN_CMD;
        end
      endcase
    end else if (!awaiting_y) begin
      acc_x_next      = sum_x;
      awaiting_y_next = 1'b1;
      if (end_of_stream) begin
        res_valid  = 1'b1;
        res.status = vtgd_pkg::STATUS_TRUNCATED;
      end
    end else begin
      acc_y_next           = sum_y;
      awaiting_y_next      = 1'b0;
      remaining_count_next = remaining_count - {{(vtgd_pkg::COUNT_W-1){1'b0}}, 1'b1};
      res_valid            = 1'b1;
      if (!x_fits || !y_fits) begin
        failed_next = 1'b1;
        res.status  = vtgd_pkg::STATUS_OUT_OF_RANGE;
      end else begin
        first_load         = starts || !path_nonempty;
        path_nonempty_next = 1'b1;
        res.point_x        = acc_x[vtgd_pkg::WORD_W-1:0];
        res.point_y        = sum_y[vtgd_pkg::WORD_W-1:0];
        res.starts_path    = starts;
      end
    end

    // Clear everything after the feature's last word
    if (end_of_stream) begin
      command_id_next      = vtgd_pkg::CMD_MOVE_TO;
      remaining_count_next = '0;
      awaiting_y_next      = 1'b0;
      acc_x_next           = '0;
      acc_y_next           = '0;
      path_nonempty_next   = 1'b0;
      failed_next          = 1'b0;
    end
  end

  // Decoder control state
  always_ff @(posedge clk) begin
    if (rst) begin
      command_id      <= vtgd_pkg::CMD_MOVE_TO;
      remaining_count <= '0;
      awaiting_y      <= 1'b0;
      acc_x           <= '0;
      acc_y           <= '0;
      path_nonempty   <= 1'b0;
      failed          <= 1'b0;
    end else if (accept) begin
      command_id      <= command_id_next;
      remaining_count <= remaining_count_next;
      awaiting_y      <= awaiting_y_next;
      acc_x           <= acc_x_next;
      acc_y           <= acc_y_next;
      path_nonempty   <= path_nonempty_next;
      failed          <= failed_next;
    end
  end

  // Capture the first point of a path
  always_ff @(posedge clk) begin
    if (accept && first_load) begin
      path_first_x <= acc_x[vtgd_pkg::WORD_W-1:0];
      path_first_y <= sum_y[vtgd_pkg::WORD_W-1:0];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/vtgd_out_buf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vtgd_out_buf
// Output register with a skid stage so the input side keeps going while one
// result beat waits on out_ready.
// ----------------------------------------------------------------------------
module vtgd_out_buf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  vtgd_pkg::result_t      push_data,
  output logic                   space,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output vtgd_pkg::result_t      out_data
);

  logic              skid_valid;
  vtgd_pkg::result_t skid_data;
  logic              pop;

  assign pop   = out_valid && out_ready;
  assign space = !skid_valid;

  // Track occupancy of the output and skid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Move payload beats
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/vector_tile_geometry_decoder.sv
// A result beat is registered into the output buffer when its word is accepted.
// Throughput: one word per cycle while in_ready is high; in_ready drops while the skid register is full.
// A two-beat output buffer keeps in_ready high while one result waits on out_ready.
// Reset (rst, synchronous): decoder state returns to MoveTo with empty path, no error,
// and the output buffer empties; stored path start point is not cleared.
`default_nettype none
// ----------------------------------------------------------------------------
// vector_tile_geometry_decoder
// Decodes vector-tile geometry words into absolute points with path marks.
// ----------------------------------------------------------------------------
module vector_tile_geometry_decoder (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [31:0]                  word,
  input  wire logic                         end_of_stream,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [31:0]                point_x,
  output logic signed [31:0]                point_y,
  output logic                              starts_path,
  output logic                              closes_path,
  output logic [1:0]                        status,
  output logic                              last
);

  logic              accept;
  logic              res_valid;
  vtgd_pkg::result_t res;
  vtgd_pkg::result_t out_data;

  assign accept = in_valid && in_ready;

  // Per-word decode and state update
  vtgd_step u_step (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .word          (word),
    .end_of_stream (end_of_stream),
    .res_valid     (res_valid),
    .res           (res)
  );

  // Hold result beats until taken
  vtgd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && res_valid),
    .push_data (res),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign point_x     = out_data.point_x;
  assign point_y     = out_data.point_y;
  assign starts_path = out_data.starts_path;
  assign closes_path = out_data.closes_path;
  assign status      = out_data.status;
  assign last        = out_data.last;

endmodule
`default_nettype wire

FILE: bench/tb_vector_tile_geometry_decoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vector_tile_geometry_decoder
// Self-checking bench for the vector tile geometry decoder. A scoreboard
// class keeps its own model of the decoder state and predicts every point
// beat from the accepted words. Directed features cover the coordinate
// extremes, path marks and every error kind. Random features follow, mostly
// well-formed, some cut short and some plain noise. Both ports idle at random.
// ----------------------------------------------------------------------------
module tb_vector_tile_geometry_decoder;

  localparam longint INT32_MIN   = -(longint'(1) <<< 31);
  localparam longint INT32_MAX   = (longint'(1) <<< 31) - 1;
  localparam int     LIVE_WORDS  = 800;
  localparam int     HOLD_CYCLES = 300;
  localparam int     MAX_REPORTS = 10;

  // Predict point beats from accepted words and check the beats that come out
  class point_scoreboard;
    vtgd_pkg::result_t              expected[$];
    int                             n_errors;
    int                             n_checked;
    int                             n_live;
    logic [2:0]                     cmd;
    logic [vtgd_pkg::COUNT_W-1:0]   remaining;
    bit                             awaiting_y;
    longint                         acc_x;
    longint                         acc_y;
    logic signed [31:0]             first_x;
    logic signed [31:0]             first_y;
    bit                             nonempty;
    bit                             failed;

    function new();
      n_errors  = 0;
      n_checked = 0;
      n_live    = 0;
      first_x   = '0;
      first_y   = '0;
      clear();
    endfunction

    // Return to the start-of-feature state; the path start is kept
    function void clear();
      cmd        = vtgd_pkg::CMD_MOVE_TO;
      remaining  = '0;
      awaiting_y = 1'b0;
      acc_x      = 0;
      acc_y      = 0;
      nonempty   = 1'b0;
      failed     = 1'b0;
    endfunction

    function longint unzigzag(input logic [31:0] n);
      logic [31:0] v;
      v = (n >> 1) ^ {32{n[0]}};
      return longint'($signed(v));
    endfunction

    function bit beyond_int32(input longint v);
      return (v < INT32_MIN) || (v > INT32_MAX);
    endfunction

    // Advance the model by one accepted word
    function void note_word(input logic [31:0] w, input logic eos);
      vtgd_pkg::result_t r;
      bit                hit;
      bit                opens;
      logic [2:0]        id;
      r      = '0;
      r.last = eos;
      hit    = 1'b0;
      opens  = 1'b0;
      id     = w[2:0];
      if (failed) begin
        if (eos) clear();
        return;
      end
      n_live++;
      if (remaining == 0) begin
        cmd = id;
        if (id == vtgd_pkg::CMD_MOVE_TO || id == vtgd_pkg::CMD_LINE_TO) begin
          remaining  = w[31:3];
          awaiting_y = 1'b0;
          if (eos && w[31:3] != 0) begin
            hit      = 1'b1;
            r.status = vtgd_pkg::STATUS_TRUNCATED;
          end
        end else if (id == vtgd_pkg::CMD_CLOSE_PATH) begin
          if (nonempty) begin
            hit           = 1'b1;
            r.point_x     = first_x;
            r.point_y     = first_y;
            r.closes_path = 1'b1;
          end
        end else begin
          failed   = 1'b1;
          hit      = 1'b1;
          r.status = vtgd_pkg::STATUS_UNKNOWN_CMD;
        end
      end else if (!awaiting_y) begin
        acc_x      += unzigzag(w);
        awaiting_y = 1'b1;
        if (eos) begin
          hit      = 1'b1;
          r.status = vtgd_pkg::STATUS_TRUNCATED;
        end
      end else begin
        acc_y      += unzigzag(w);
        awaiting_y = 1'b0;
        remaining--;
        hit        = 1'b1;
        if (beyond_int32(acc_x) || beyond_int32(acc_y)) begin
          failed   = 1'b1;
          r.status = vtgd_pkg::STATUS_OUT_OF_RANGE;
        end else begin
          opens = (cmd == vtgd_pkg::CMD_MOVE_TO) && nonempty;
          if (opens || !nonempty) begin
            first_x = 32'(acc_x);
            first_y = 32'(acc_y);
          end
          nonempty      = 1'b1;
          r.point_x     = 32'(acc_x);
          r.point_y     = 32'(acc_y);
          r.starts_path = opens;
        end
      end
      if (hit) expected = {expected, r};
      if (eos) clear();
    endfunction

    function void report(input string what, input vtgd_pkg::result_t want,
                         input vtgd_pkg::result_t got);
      n_errors++;
      if (n_errors <= MAX_REPORTS)
        $display("%s at beat %0d: ", what, n_checked,
                 "want x=%0d y=%0d sp=%0b cp=%0b st=%0d last=%0b, ",
                 want.point_x, want.point_y, want.starts_path, want.closes_path,
                 want.status, want.last,
                 "got x=%0d y=%0d sp=%0b cp=%0b st=%0d last=%0b",
                 got.point_x, got.point_y, got.starts_path, got.closes_path,
                 got.status, got.last);
    endfunction

    // Compare one output beat with the oldest prediction
    function void check_point(input vtgd_pkg::result_t got);
      vtgd_pkg::result_t want;
      n_checked++;
      if (expected.size() == 0) begin
        report("unexpected beat", '0, got);
        return;
      end
      want = expected.pop_front();
      if (got.point_x !== want.point_x || got.point_y !== want.point_y ||
          got.starts_path !== want.starts_path || got.closes_path !== want.closes_path ||
          got.status !== want.status || got.last !== want.last)
        report("mismatch", want, got);
    endfunction
  endclass

  logic               clk;
  logic               rst           = 1'b1;
  logic               in_valid      = 1'b0;
  logic               in_ready;
  logic [31:0]        word          = '0;
  logic               end_of_stream = 1'b0;
  logic               out_valid;
  logic               out_ready     = 1'b0;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic               starts_path;
  logic               closes_path;
  logic [1:0]         status;
  logic               last;

  logic               rx_hold       = 1'b0;
  bit                 tx_calm       = 1'b0;
  vtgd_pkg::result_t  out_beat;

  point_scoreboard    sb = new();

  vector_tile_geometry_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .word          (word),
    .end_of_stream (end_of_stream),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .point_x       (point_x),
    .point_y       (point_y),
    .starts_path   (starts_path),
    .closes_path   (closes_path),
    .status        (status),
    .last          (last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watch both ports; note accepted words and check accepted beats
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_word(word, end_of_stream);
      if (out_valid && out_ready) begin
        out_beat = {point_x, point_y, starts_path, closes_path, status, last};
        sb.check_point(out_beat);
      end
    end
  end

  function automatic logic [31:0] zigzag_encode(input int d);
    return (d <<< 1) ^ (d >>> 31);
  endfunction

  function automatic logic [31:0] cmd_word(input logic [2:0] id, input logic [28:0] cnt);
    return {cnt, id};
  endfunction

  function automatic logic [31:0] random_delta();
    if ($urandom_range(0, 15) == 0) return $urandom();
    return zigzag_encode(int'($urandom_range(0, 4000)) - 2000);
  endfunction

  // Offer one word after a random gap and hold it until accepted
  task automatic send_word(input logic [31:0] w, input logic eos);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    word          <= w;
    end_of_stream <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_feature(input logic [31:0] feat[$]);
    foreach (feat[i]) send_word(feat[i], i == feat.size() - 1);
  endtask

  // Build one random feature: well-formed, cut short, or noise
  task automatic run_random_feature();
    logic [31:0] feat[$];
    int          kind;
    int          ncmd;
    int          sel;
    int          cnt;
    int          cut;
    logic [2:0]  id;
    kind    = $urandom_range(0, 9);
    tx_calm = ($urandom_range(0, 3) == 0);
    if (kind == 9) begin
      repeat ($urandom_range(1, 6)) feat = {feat, 32'($urandom())};
    end else begin
      ncmd = $urandom_range(1, 4);
      for (int c = 0; c < ncmd; c++) begin
        sel = (c == 0) ? 5 : $urandom_range(0, 9);
        if (sel <= 4) begin
          cnt  = $urandom_range(0, 4);
          feat = {feat, cmd_word(vtgd_pkg::CMD_LINE_TO, 29'(cnt))};
        end else if (sel <= 6) begin
          cnt  = $urandom_range(1, 2);
          feat = {feat, cmd_word(vtgd_pkg::CMD_MOVE_TO, 29'(cnt))};
        end else if (sel <= 8) begin
          cnt  = 0;
          feat = {feat, cmd_word(vtgd_pkg::CMD_CLOSE_PATH, 29'($urandom() >> 3))};
        end else begin
          // huge count left unfinished, or an unknown id
          if ($urandom_range(0, 1) == 0) begin
            id = $urandom_range(0, 1) ? vtgd_pkg::CMD_MOVE_TO : vtgd_pkg::CMD_LINE_TO;
            cnt = $urandom_range(1, 2);
          end else begin
            id = 3'($urandom_range(3, 7));
            if (id == vtgd_pkg::CMD_CLOSE_PATH) id = 3'd0;
            cnt = 0;
          end
          feat = {feat, cmd_word(id, 29'($urandom() >> 3))};
          repeat (cnt) begin
            feat = {feat, random_delta()};
            feat = {feat, random_delta()};
          end
          break;
        end
        repeat (cnt) begin
          feat = {feat, random_delta()};
          feat = {feat, random_delta()};
        end
      end
      if (kind >= 7) begin
        cut = $urandom_range(1, feat.size());
        while (feat.size() > cut) void'(feat.pop_back());
      end
    end
    send_feature(feat);
  endtask

  // Lower valid and wait until every predicted beat has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected.size() != 0) @(posedge clk);
  endtask

  // Receiver: random gap after each beat, calm stretches, and the long hold
  initial begin
    int wait_left;
    int calm_left;
    wait_left = 0;
    calm_left = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (out_valid && out_ready) begin
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 19) == 0) calm_left = 40;
        wait_left = (calm_left > 0) ? 0 : $urandom_range(0, 4);
      end else if (wait_left > 0) begin
        wait_left--;
      end
      out_ready <= (wait_left == 0) && !rx_hold;
      @(posedge clk);
    end
  end

  // Hold the output off long enough for the block to back up its input
  initial begin
    @(posedge clk);
    while (sb.n_checked < 150) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

  // Main sequence: reset, directed features, random features, drain
  initial begin
    bit paused;
    paused = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // points, ClosePath with ignored count, MoveTo opening a new path,
    // zero-count LineTo at the end of the stream
    send_feature('{cmd_word(vtgd_pkg::CMD_MOVE_TO, 29'd1),
                   zigzag_encode(5), zigzag_encode(-3),
                   cmd_word(vtgd_pkg::CMD_CLOSE_PATH, 29'd3),
                   cmd_word(vtgd_pkg::CMD_MOVE_TO, 29'd1),
                   zigzag_encode(1), zigzag_encode(1),
                   cmd_word(vtgd_pkg::CMD_LINE_TO, 29'd0)});
    // largest and smallest deltas, ClosePath as the last word
    send_feature('{cmd_word(vtgd_pkg::CMD_MOVE_TO, 29'd1), 32'hFFFF_FFFE, 32'hFFFF_FFFF,
                   cmd_word(vtgd_pkg::CMD_CLOSE_PATH, 29'd0)});
    // ClosePath on an empty path, full count left unused at the end
    send_feature('{cmd_word(vtgd_pkg::CMD_CLOSE_PATH, 29'd0),
                   cmd_word(vtgd_pkg::CMD_MOVE_TO, 29'h1FFF_FFFF),
                   32'h0, 32'h0});
    // unknown command, then a dropped end word
    send_feature('{32'h0, 32'hFFFF_FFFF});
    send_feature('{cmd_word(3'd3, 29'h1FFF_FFFF)});
    send_feature('{cmd_word(3'd6, 29'd0)});
    // x runs past the signed 32-bit range
    send_feature('{cmd_word(vtgd_pkg::CMD_MOVE_TO, 29'd2),
                   32'hFFFF_FFFE, 32'h0, 32'hFFFF_FFFE, 32'h0});
    // stream cut on a dx word, and on a command word with a count
    send_feature('{cmd_word(vtgd_pkg::CMD_LINE_TO, 29'd1), zigzag_encode(7)});
    send_feature('{cmd_word(vtgd_pkg::CMD_MOVE_TO, 29'd3)});

    while (sb.n_live < LIVE_WORDS) begin
      if (!paused && sb.n_live >= LIVE_WORDS / 2) begin
        paused = 1'b1;
        drain();
      end
      run_random_feature();
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.n_errors == 0 && sb.expected.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: files.f
hdl/vtgd_pkg.sv
hdl/vtgd_step.sv
hdl/vtgd_out_buf.sv
hdl/vector_tile_geometry_decoder.sv
bench/tb_vector_tile_geometry_decoder.sv
